/* rtl/core/bmhq_pkg.sv */
// Shared constants for the binary min-heap queue: field widths, request
// codes and result status codes. No dependencies.
package bmhq_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_TILE_BITS = 16;

  localparam int KEY_W    = 10;
  localparam int TRACK_W  = 4;
  localparam int DEPTH_W  = 8;
  localparam int USTATE_W = 8;
  localparam int STATUS_W = 2;

  // Item layout below the tile: {length, track, depth, user state, origin}
  localparam int ITEM_W  = KEY_W + TRACK_W + DEPTH_W + USTATE_W + TRACK_W;
  localparam int KEY_LSB = ITEM_W - KEY_W;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* rtl/core/bmhq_store.sv */
// Heap entry storage: one write port, two read ports, registered read data.
// Depends on bmhq_pkg for default sizes.
module bmhq_store #(
  parameter int DEPTH = bmhq_pkg::DEF_CAPACITY,
  parameter int W     = bmhq_pkg::DEF_TILE_BITS + bmhq_pkg::ITEM_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [W-1:0]             wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  input  logic [$clog2(DEPTH)-1:0] rb,
  output logic [W-1:0]             rd_a,
  output logic [W-1:0]             rd_b
);

  logic [W-1:0] mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Register both read ports
  always_ff @(posedge clk) begin
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

endmodule

/* rtl/core/bmhq_out_fifo.sv */
// Two-beat result buffer between the heap sequencer and the output channel.
// Depends on bmhq_pkg for the default width.
module bmhq_out_fifo #(
  parameter int W = bmhq_pkg::STATUS_W + bmhq_pkg::DEF_TILE_BITS + bmhq_pkg::ITEM_W + 9
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;
  logic         take;

  assign rd_valid = (fill != 2'd0);
  assign full     = (fill == 2'd2);
  assign take     = rd_valid && rd_ready;
  assign rd_data  = slot[rptr];

  // Hold the beat payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wptr] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (take) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, wr_en} - {1'b0, take};
    end
  end

endmodule

/* rtl/core/binary_min_heap_queue_unit.sv */
// Binary min-heap priority queue keyed on path length.
// Input channel (in_valid/in_ready): one request beat, push (req_type 0)
// carrying an item, or pop (req_type 1). Output channel (out_valid/out_ready):
// exactly one result beat per request with status, the popped item (zero for
// pushes and failed pops) and the entry count after the request.
// Push and empty-pop results are queued on the accept cycle; other pop results
// in the next cycle, once the root and last entry come back from the store.
// Between accepted requests the unit runs the sift: a push climbs from the new
// last position, reading the parent and then comparing and writing back per
// level, and a pop moves the last entry to the root and descends the same way;
// a full push or an empty pop stays idle, and popping the last item ends after
// the fetch. At 256 entries the longest sift is a push climbing eight levels.
// The sift loop alternates reading the store with comparing or writing back,
// through a single write port.
// A new request is taken once the sift finishes, while up to one earlier
// result still waits in the two-beat output buffer; a stalled receiver holds
// off requests only when both buffer slots are full.
// Reset (synchronous, rst high) empties the heap and the output buffer; the
// store contents are not cleared, only entries below the count are read.
// Depends on bmhq_pkg, bmhq_store and bmhq_out_fifo.
module binary_min_heap_queue_unit #(
  parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
  parameter int TILE_BITS = bmhq_pkg::DEF_TILE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [TILE_BITS-1:0]           tile,
  input  logic [bmhq_pkg::KEY_W-1:0]     path_length,
  input  logic [bmhq_pkg::TRACK_W-1:0]   track,
  input  logic [bmhq_pkg::DEPTH_W-1:0]   branch_depth,
  input  logic [bmhq_pkg::USTATE_W-1:0]  user_state,
  input  logic [bmhq_pkg::TRACK_W-1:0]   origin_track,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bmhq_pkg::STATUS_W-1:0]  status,
  output logic [TILE_BITS-1:0]           out_tile,
  output logic [bmhq_pkg::KEY_W-1:0]     out_length,
  output logic [bmhq_pkg::TRACK_W-1:0]   out_track,
  output logic [bmhq_pkg::DEPTH_W-1:0]   out_depth,
  output logic [bmhq_pkg::USTATE_W-1:0]  out_state,
  output logic [bmhq_pkg::TRACK_W-1:0]   out_origin_track,
  output logic [$clog2(CAPACITY+1)-1:0]  entry_count_out
);

  import bmhq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = TILE_BITS + ITEM_W;
  localparam int RW = STATUS_W + EW + CW;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE     = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  state_t          state;
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   pos;
  logic [EW-1:0]   item;

  logic            accept;
  logic [EW-1:0]   in_entry;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [EW-1:0]   mem_wd;
  logic [AW-1:0]   mem_ra;
  logic [AW-1:0]   mem_rb;
  logic [EW-1:0]   rd_a;
  logic [EW-1:0]   rd_b;
  logic            fifo_wr;
  logic [RW-1:0]   fifo_wd;
  logic            fifo_full;
  logic [RW-1:0]   fifo_rd;

  logic [CW-1:0]   pos_m1;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   parent;
  logic [CW-1:0]   parent_m1;
  logic [CW:0]     child;
  logic [CW:0]     child_m1;
  logic [CW:0]     n_ext;
  logic            child_out;
  logic            right_ok;
  logic            take_right;
  logic [EW-1:0]   sel;
  logic [CW-1:0]   sel_pos;
  logic            up_move;
  logic            dn_stop;
  logic            heap_full;

  assign in_entry = {tile, path_length, track, branch_depth, user_state, origin_track};
  assign in_ready = (state == S_IDLE) && !fifo_full;
  assign accept   = in_valid && in_ready;

  // Heap position arithmetic
  assign pos_m1     = pos - ONE;
  assign cnt_m1     = entry_count - ONE;
  assign parent     = pos >> 1;
  assign parent_m1  = parent - ONE;
  assign child      = {pos, 1'b0};
  assign child_m1   = child - (CW+1)'(1);
  assign n_ext      = {1'b0, entry_count};
  assign child_out  = (child > n_ext);
  assign right_ok   = (child != n_ext);
  assign heap_full  = (entry_count == CAP_CNT);

  // Compare keys of the moving item and the fetched neighbors
  assign take_right = right_ok && (rd_a[KEY_LSB +: KEY_W] > rd_b[KEY_LSB +: KEY_W]);
  assign sel        = take_right ? rd_b : rd_a;
  assign sel_pos    = take_right ? (child[CW-1:0] + ONE) : child[CW-1:0];
  assign up_move    = (item[KEY_LSB +: KEY_W] < rd_a[KEY_LSB +: KEY_W]);
  assign dn_stop    = (item[KEY_LSB +: KEY_W] <= sel[KEY_LSB +: KEY_W]);

  // Drive store ports and result beats
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = pos_m1[AW-1:0];
    mem_wd  = item;
    mem_ra  = '0;
    mem_rb  = cnt_m1[AW-1:0];
    fifo_wr = 1'b0;
    fifo_wd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_PUSH) begin
            fifo_wr = 1'b1;
            if (heap_full) begin
              fifo_wd = {ST_FULL, {EW{1'b0}}, entry_count};
            end else begin
              fifo_wd = {ST_OK, {EW{1'b0}}, entry_count + ONE};
            end
          end else if (entry_count == '0) begin
            fifo_wr = 1'b1;
            fifo_wd = {ST_EMPTY, {EW{1'b0}}, entry_count};
          end
        end
      end
      S_POP_RD: begin
        fifo_wr = 1'b1;
        fifo_wd = {ST_OK, rd_a, entry_count};
      end
      S_UP_RD: begin
        mem_ra = parent_m1[AW-1:0];
        if (pos == ONE) begin
          mem_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_move) begin
          mem_wd = rd_a;
        end
      end
      S_DN_RD: begin
        mem_ra = child_m1[AW-1:0];
        mem_rb = child[AW-1:0];
        if (child_out) begin
          mem_we = 1'b1;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (!dn_stop) begin
          mem_wd = sel;
        end
      end
      default: ;
    endcase
  end

  // Sequence push, pop and sift steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == REQ_PUSH) begin
              if (!heap_full) begin
                item        <= in_entry;
                entry_count <= entry_count + ONE;
                pos         <= entry_count + ONE;
                state       <= S_UP_RD;
              end
            end else if (entry_count != '0) begin
              entry_count <= cnt_m1;
              state       <= S_POP_RD;
            end
          end
        end
        S_POP_RD: begin
          if (entry_count == '0) begin
            state <= S_IDLE;
          end else begin
            item  <= rd_b;
            pos   <= ONE;
            state <= S_DN_RD;
          end
        end
        S_UP_RD: begin
          state <= (pos == ONE) ? S_IDLE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DN_RD: begin
          state <= child_out ? S_IDLE : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_stop) begin
            state <= S_IDLE;
          end else begin
            pos   <= sel_pos;
            state <= S_DN_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bmhq_store #(
    .DEPTH (CAPACITY),
    .W     (EW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .wa   (mem_wa),
    .wd   (mem_wd),
    .ra   (mem_ra),
    .rb   (mem_rb),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  bmhq_out_fifo #(
    .W (RW)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fifo_wr),
    .wr_data  (fifo_wd),
    .full     (fifo_full),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (fifo_rd)
  );

  assign {status, out_tile, out_length, out_track, out_depth, out_state,
          out_origin_track, entry_count_out} = fifo_rd;

  // Count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CAP_CNT)
    else $error("entry count above capacity");

  // Store writes land inside the live heap
  a_write_in_heap: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (pos != '0) && (pos <= entry_count))
    else $error("store write outside live entries");

  // Result beats never overrun the output buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_wr |-> !fifo_full)
    else $error("result buffer overflow");

  // A pop of a non-empty heap fetches root and last entry next
  a_pop_fetch: assert property (@(posedge clk) disable iff (rst)
    accept && (req_type == REQ_POP) && (entry_count != '0) |=> state == S_POP_RD)
    else $error("pop did not fetch root");

  // Sift-down compares only children inside the heap
  a_child_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_CMP) |-> !child_out)
    else $error("sift-down compared past heap end");

endmodule
